/* rtl/core/array_linked_list_manager_assert.svh */
// Assertion macros shared by the list manager RTL.
`ifndef ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH
`define ARRAY_LINKED_LIST_MANAGER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ALLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define ALLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/allm_pkg.sv */
// Types and codes of the array linked list manager.
`default_nettype none
package allm_pkg;

    localparam int NODE_SLOTS_DEF = 1024;

    localparam int ACT_W   = 2;
    localparam int SLOT_W  = 10;
    localparam int VALUE_W = 64;
    localparam int STAT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BEFORE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE     = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [SLOT_W-1:0]  slot_index;
        logic [VALUE_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] new_slot;
        logic [SLOT_W-1:0] first_slot;
        logic [SLOT_W-1:0] last_slot;
        logic [SLOT_W-1:0] element_count;
    } t_rsp;

endpackage
`default_nettype wire

/* rtl/core/allm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module allm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/array_linked_list_manager.sv */
// Top level of the array linked list manager: sequencer around the link stores.
// A doubly linked list lives in NODE_SLOTS slots of two link RAMs (next and prev)
// plus a value RAM; slot 0 is the sentinel and free slots chain through the next
// links. After reset a clearing pass over every slot rebuilds the sentinel
// and free chain, with o_in_ready low. A rejected request (bad index, sentinel
// removal, unknown action, store full) is answered from the idle state. An accepted
// insert or remove is worked in order: the request's own next and prev links are
// read in the accept cycle, the free head's next link in S_RDB, then S_WR1 and
// S_WR2 commit the new links, since each link RAM has one write port. One request is
// worked at a time; there is one result register, so a result word that waits
// holds off the next request until the word is taken (the take and the next
// accept may share a cycle). First and last slot come from register copies of
// the sentinel links.
`default_nettype none
`include "array_linked_list_manager_assert.svh"
module array_linked_list_manager #(
    parameter int NODE_SLOTS = allm_pkg::NODE_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire allm_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output allm_pkg::t_rsp     o_out_data
);
    import allm_pkg::*;

    localparam int IW = $clog2(NODE_SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(NODE_SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_RDB  = 5'b00100,
        S_WR1  = 5'b01000,
        S_WR2  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [IW-1:0]      r_clr;
    logic [ACT_W-1:0]   r_act;
    logic [IW-1:0]      r_e;
    logic [VALUE_W-1:0] r_val;
    logic [IW-1:0]      r_nx, r_pv, r_fr_next;
    logic [IW-1:0]      r_free, n_free;
    logic [IW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_first, n_first;
    logic [IW-1:0]      r_last, n_last;
    logic               r_out_valid;
    t_rsp               r_out;

    logic               nxt_we, prv_we, val_we;
    logic [IW-1:0]      nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
    logic [IW-1:0]      prv_waddr, prv_wdata, prv_rdata;
    logic [IW-1:0]      val_waddr;
    logic [VALUE_W-1:0] val_wdata;

    logic          accept;
    logic          bad, full;
    logic [IW-1:0] in_slot;
    logic          is_remove, is_after;

    allm_ram #(.WIDTH(IW), .DEPTH(NODE_SLOTS)) u_next (
        .i_clk  (i_clk),
        .i_we   (nxt_we),
        .i_waddr(nxt_waddr),
        .i_wdata(nxt_wdata),
        .i_raddr(nxt_raddr),
        .o_rdata(nxt_rdata)
    );

    allm_ram #(.WIDTH(IW), .DEPTH(NODE_SLOTS)) u_prev (
        .i_clk  (i_clk),
        .i_we   (prv_we),
        .i_waddr(prv_waddr),
        .i_wdata(prv_wdata),
        .i_raddr(in_slot),
        .o_rdata(prv_rdata)
    );

    // Values are kept for the node store but never show up in a result word.
    allm_ram #(.WIDTH(VALUE_W), .DEPTH(NODE_SLOTS)) u_value (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_raddr(r_e),
        .o_rdata()
    );

    assign in_slot    = IW'(i_in_data.slot_index);
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign is_remove  = (r_act == ACT_REMOVE);
    assign is_after   = (r_act == ACT_INS_AFTER);

    always_comb begin
        bad = (i_in_data.action != ACT_INS_AFTER) && (i_in_data.action != ACT_INS_BEFORE)
              && (i_in_data.action != ACT_REMOVE);
        if (32'(i_in_data.slot_index) >= 32'(NODE_SLOTS)) begin
            bad = 1'b1;
        end
        if ((i_in_data.action == ACT_REMOVE) && (i_in_data.slot_index == '0)) begin
            bad = 1'b1;
        end
        full = !bad && (i_in_data.action != ACT_REMOVE) && (r_count >= LAST_SLOT);
    end

    // Next links are read at the request slot on accept, at the free head after.
    assign nxt_raddr = (r_state == S_IDLE) ? in_slot : r_free;

    always_comb begin
        n_state   = r_state;
        nxt_we    = 1'b0;
        nxt_waddr = r_e;
        nxt_wdata = r_free;
        prv_we    = 1'b0;
        prv_waddr = r_e;
        prv_wdata = '0;
        val_we    = 1'b0;
        val_waddr = r_e;
        val_wdata = r_val;
        n_free    = r_free;
        n_count   = r_count;
        case (r_state)
            S_CLR: begin
                nxt_we    = 1'b1;
                nxt_waddr = r_clr;
                nxt_wdata = ((r_clr == '0) || (r_clr == LAST_SLOT)) ? '0 : IW'(r_clr + 1'b1);
                prv_we    = 1'b1;
                prv_waddr = r_clr;
                prv_wdata = '0;
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && !bad && !full) begin
                    n_state = S_RDB;
                end
            end
            S_RDB: begin
                n_state = S_WR1;
            end
            S_WR1: begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
                if (is_remove) begin
                    nxt_waddr = r_pv;
                    nxt_wdata = r_nx;
                    prv_waddr = r_nx;
                    prv_wdata = r_pv;
                end else if (is_after) begin
                    nxt_waddr = r_e;
                    nxt_wdata = r_free;
                    prv_waddr = r_nx;
                    prv_wdata = r_free;
                end else begin
                    nxt_waddr = r_pv;
                    nxt_wdata = r_free;
                    prv_waddr = r_e;
                    prv_wdata = r_free;
                end
                n_state = S_WR2;
            end
            S_WR2: begin
                nxt_we = 1'b1;
                prv_we = 1'b1;
                val_we = 1'b1;
                if (is_remove) begin
                    nxt_waddr = r_e;
                    nxt_wdata = r_free;
                    prv_waddr = r_e;
                    prv_wdata = '0;
                    val_waddr = r_e;
                    val_wdata = '0;
                    n_free    = r_e;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end else begin
                    nxt_waddr = r_free;
                    nxt_wdata = is_after ? r_nx : r_e;
                    prv_waddr = r_free;
                    prv_wdata = is_after ? r_e : r_pv;
                    val_waddr = r_free;
                    val_wdata = r_val;
                    n_free    = r_fr_next;
                    n_count   = r_count + 1'b1;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // Mirror the sentinel links so first and last need no extra reads.
    always_comb begin
        n_first = r_first;
        n_last  = r_last;
        if (nxt_we && (nxt_waddr == '0)) begin
            n_first = nxt_wdata;
        end
        if (prv_we && (prv_waddr == '0)) begin
            n_last = prv_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_free      <= IW'(1);
            r_count     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            r_count <= n_count;
            r_first <= n_first;
            r_last  <= n_last;
            if (r_state == S_CLR) begin
                r_clr <= IW'(r_clr + 1'b1);
            end
            if (accept && (bad || full)) begin
                r_out_valid <= 1'b1;
            end else if (r_state == S_WR2) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_in_data.action;
            r_e   <= in_slot;
            r_val <= i_in_data.payload;
        end
        if (r_state == S_RDB) begin
            r_nx <= nxt_rdata;
            r_pv <= prv_rdata;
        end
        if (r_state == S_WR1) begin
            r_fr_next <= nxt_rdata;
        end
        if (accept && (bad || full)) begin
            r_out.status        <= bad ? ST_BAD : ST_FULL;
            r_out.new_slot      <= '0;
            r_out.first_slot    <= SLOT_W'(r_first);
            r_out.last_slot     <= SLOT_W'(r_last);
            r_out.element_count <= SLOT_W'(r_count);
        end else if (r_state == S_WR2) begin
            r_out.status        <= ST_OK;
            r_out.new_slot      <= is_remove ? '0 : SLOT_W'(r_free);
            r_out.first_slot    <= SLOT_W'(n_first);
            r_out.last_slot     <= SLOT_W'(n_last);
            r_out.element_count <= SLOT_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ALLM_ASSERT_NOW(a_count_cap, 1'b1, r_count <= LAST_SLOT, "node count above capacity")
    `ALLM_ASSERT_NEXT(a_wr2_result, r_state == S_WR2, r_out_valid && (r_out.status == ST_OK), "committed request gave no ok result")
    `ALLM_ASSERT_NEXT(a_clear_end, (r_state == S_CLR) && (r_clr == LAST_SLOT), (r_state == S_IDLE) && (r_first == '0) && (r_last == '0), "clearing pass did not end cleanly")
    `ALLM_ASSERT_NOW(a_free_ok, (r_state == S_WR2) && !is_remove, r_count < LAST_SLOT, "insert committed into a full store")

endmodule
`default_nettype wire
